FILE: rtl/core/jtl_pkg.sv
// Package for the JSON token lexer: token kinds, error codes, scanner modes
// and the result record. No dependencies.
package jtl_pkg;

    typedef enum logic [3:0] {
        K_LBRACE = 4'd0, K_RBRACE = 4'd1, K_LBRACK = 4'd2, K_RBRACK = 4'd3,
        K_COLON = 4'd4, K_COMMA = 4'd5, K_STRING = 4'd6, K_ESTRING = 4'd7,
        K_BOOL = 4'd8, K_NULL = 4'd9, K_INT = 4'd10, K_DOUBLE = 4'd11,
        K_END = 4'd12
    } t_kind;

    typedef enum logic [3:0] {
        E_NONE = 4'd0, E_TOKEN = 4'd1, E_USTR = 4'd2, E_UESC = 4'd3,
        E_ESC = 4'd4, E_UNI = 4'd5, E_CTRL = 4'd6, E_UTF8 = 4'd7,
        E_LIT = 4'd8, E_NUM = 4'd9, E_LZERO = 4'd10
    } t_err;

    typedef enum logic [4:0] {
        M_IDLE, M_STR, M_ESC, M_HEX, M_UTF, M_LIT, M_NSIGN, M_NZERO,
        M_NINT, M_NFRAC0, M_NFRAC, M_NEXP0, M_NEXPSIGN, M_NEXP
    } t_mode;

    // One result as it leaves the block.
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] toff;
        logic [31:0] tlen;
        logic [3:0]  err;
        logic [31:0] eoff;
    } t_res;

    localparam int RES_BITS = $bits(t_res);

    // Literal letters: true, false, null.
    function automatic logic [7:0] lit_char(input logic [1:0] sel, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        case (sel)
            2'd0: case (idx)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            2'd1: case (idx)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'h00;
            endcase
            default: case (idx)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/jtl_out_buf.sv
// Three-entry result queue between the scanner and the output stream.
// Depends on jtl_pkg.
module jtl_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [1:0]    i_cnt,
    input  jtl_pkg::t_res i_res0,
    input  jtl_pkg::t_res i_res1,
    output logic          o_space,
    output logic          o_valid,
    input  logic          i_ready,
    output jtl_pkg::t_res o_res,
    output logic          o_last
);
    import jtl_pkg::*;

    // Each entry carries its last flag; the scanner pushes one or two at once.
    t_res       r_e0, r_e1, r_e2;
    logic       r_l0, r_l1, r_l2;
    logic [1:0] r_n;
    t_res       n_e0, n_e1, n_e2;
    logic       n_l0, n_l1, n_l2;
    logic [1:0] n_n, v_n;
    logic       pop;

    assign o_valid = r_n != 2'd0;
    assign o_res   = r_e0;
    assign o_last  = r_l0;
    assign pop     = o_valid && i_ready;
    // Accept only while two slots are sure to be free after this cycle.
    assign o_space = (r_n <= 2'd1);

    always_comb begin
        n_e0 = r_e0; n_e1 = r_e1; n_e2 = r_e2;
        n_l0 = r_l0; n_l1 = r_l1; n_l2 = r_l2;
        v_n  = r_n;
        if (pop) begin
            n_e0 = r_e1; n_l0 = r_l1;
            n_e1 = r_e2; n_l1 = r_l2;
            v_n  = r_n - 2'd1;
        end
        if (i_push && i_cnt != 2'd0) begin
            case (v_n)
                2'd0: begin
                    n_e0 = i_res0; n_l0 = (i_cnt == 2'd1);
                    n_e1 = i_res1; n_l1 = 1'b1;
                end
                default: begin
                    n_e1 = i_res0; n_l1 = (i_cnt == 2'd1);
                    n_e2 = i_res1; n_l2 = 1'b1;
                end
            endcase
        end
        n_n = v_n + (i_push ? i_cnt : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 2'd0;
        end else begin
            r_n <= n_n;
        end
        r_e0 <= n_e0; r_e1 <= n_e1; r_e2 <= n_e2;
        r_l0 <= n_l0; r_l1 <= n_l1; r_l2 <= n_l2;
    end
endmodule

FILE: rtl/core/jtl_scanner.sv
// Scanner state and next-state logic: one byte or end mark per cycle, while i_step
// is high, gives up to two results. Depends on jtl_pkg.
module jtl_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    input  logic          i_eos,
    output logic [1:0]    o_cnt,
    output jtl_pkg::t_res o_res0,
    output jtl_pkg::t_res o_res1
);
    import jtl_pkg::*;

    localparam int OB = OFFSET_BITS;

    t_mode          r_mode, n_mode;
    logic [OB-1:0]  r_pos, r_start, n_start;
    logic [2:0]     r_sub, n_sub;
    logic [20:0]    r_acc, n_acc;
    logic [1:0]     r_mcls, n_mcls, r_lsel, n_lsel;
    logic           r_esc, n_esc, r_dbl, n_dbl, r_halt, n_halt;

    logic [7:0]     c;
    logic [OB-1:0]  pos;
    logic           dig, hex, ws;
    logic [20:0]    cp;
    logic [20:0]    umin;
    logic [2:0]     llen;
    logic [2:0]     subp;
    logic           tail_n;

    function automatic t_res tok(input t_kind k, input logic [OB-1:0] o,
                                 input logic [OB-1:0] l);
        t_res r;
        r = '0;
        r.kind = k;
        r.toff = 32'(o);
        r.tlen = 32'(l);
        return r;
    endfunction

    function automatic t_res erres(input t_err e, input logic [OB-1:0] o);
        t_res r;
        r = '0;
        r.err  = e;
        r.eoff = 32'(o);
        return r;
    endfunction

    assign c    = i_byte;
    assign pos  = r_pos;
    assign dig  = c >= "0" && c <= "9";
    assign hex  = dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    assign ws   = c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    assign cp   = {r_acc[14:0], c[5:0]};
    assign llen = (r_lsel == 2'd1) ? 3'd5 : 3'd4;
    assign subp = r_sub + 3'd1;
    always_comb begin
        case (r_mcls)
            2'd1: umin = 21'h80;
            2'd2: umin = 21'h800;
            2'd3: umin = 21'h10000;
            default: umin = 21'h0;
        endcase
    end

    // Results are collected into two slots; slot 0 fills first.
    t_res  s0, s1;
    logic [1:0] cnt;

    always_comb begin
        n_mode = r_mode; n_start = r_start; n_sub = r_sub; n_acc = r_acc;
        n_mcls = r_mcls; n_lsel = r_lsel; n_esc = r_esc; n_dbl = r_dbl;
        n_halt = r_halt;
        s0 = '0; s1 = '0; cnt = 2'd0;
        tail_n = 1'b0;
        if (i_eos) begin
            case (r_mode)
                M_STR: begin n_halt = 1'b1; s0 = erres(E_USTR, pos); cnt = 2'd1; end
                M_ESC: begin n_halt = 1'b1; s0 = erres(E_UESC, pos); cnt = 2'd1; end
                M_HEX: begin n_halt = 1'b1; s0 = erres(E_UNI, pos); cnt = 2'd1; end
                M_UTF: begin n_halt = 1'b1; s0 = erres(E_UTF8, pos); cnt = 2'd1; end
                M_LIT: begin n_halt = 1'b1; s0 = erres(E_LIT, pos); cnt = 2'd1; end
                M_NSIGN, M_NFRAC0, M_NEXP0, M_NEXPSIGN: begin
                    n_halt = 1'b1; s0 = erres(E_NUM, r_start); cnt = 2'd1;
                end
                M_NZERO, M_NINT, M_NFRAC, M_NEXP: begin
                    s0 = tok(r_dbl ? K_DOUBLE : K_INT, r_start, pos - r_start);
                    s1 = tok(K_END, pos, '0);
                    cnt = 2'd2;
                end
                default: begin s0 = tok(K_END, pos, '0); cnt = 2'd1; end
            endcase
            n_mode = M_IDLE;
        end else begin
            case (r_mode)
                M_STR: begin
                    if (c == 8'h22) begin
                        n_mode = M_IDLE;
                        s0 = tok(r_esc ? K_ESTRING : K_STRING, r_start,
                                 pos - r_start - OB'(1));
                        cnt = 2'd1;
                    end else if (c == 8'h5C) begin
                        n_esc = 1'b1; n_mode = M_ESC;
                    end else if (c < 8'h20) begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_CTRL, pos); cnt = 2'd1;
                    end else if (c[7]) begin
                        if ((c & 8'hE0) == 8'hC0) begin
                            n_sub = 3'd1; n_acc = {16'd0, c[4:0]}; n_mcls = 2'd1;
                            n_mode = M_UTF;
                        end else if ((c & 8'hF0) == 8'hE0) begin
                            n_sub = 3'd2; n_acc = {17'd0, c[3:0]}; n_mcls = 2'd2;
                            n_mode = M_UTF;
                        end else if ((c & 8'hF8) == 8'hF0) begin
                            n_sub = 3'd3; n_acc = {18'd0, c[2:0]}; n_mcls = 2'd3;
                            n_mode = M_UTF;
                        end else begin
                            n_halt = 1'b1; n_mode = M_IDLE;
                            s0 = erres(E_UTF8, pos); cnt = 2'd1;
                        end
                    end
                end
                M_ESC: begin
                    if (c == 8'h22 || c == 8'h5C || c == "/" || c == "b" || c == "f" ||
                        c == "n" || c == "r" || c == "t") begin
                        n_mode = M_STR;
                    end else if (c == "u") begin
                        n_sub = 3'd4; n_mode = M_HEX;
                    end else begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_ESC, pos); cnt = 2'd1;
                    end
                end
                M_HEX: begin
                    if (!hex) begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_UNI, pos); cnt = 2'd1;
                    end else begin
                        n_sub = r_sub - 3'd1;
                        if (r_sub == 3'd1) n_mode = M_STR;
                    end
                end
                M_UTF: begin
                    if (c[7:6] != 2'b10) begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_UTF8, pos); cnt = 2'd1;
                    end else begin
                        n_acc = cp;
                        n_sub = r_sub - 3'd1;
                        if (r_sub == 3'd1) begin
                            if (cp < umin || cp > 21'h10FFFF ||
                                (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
                                n_halt = 1'b1; n_mode = M_IDLE;
                                s0 = erres(E_UTF8, pos - OB'(r_mcls)); cnt = 2'd1;
                            end else begin
                                n_mode = M_STR;
                            end
                        end
                    end
                end
                M_LIT: begin
                    if (c != lit_char(r_lsel, r_sub)) begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_LIT, pos); cnt = 2'd1;
                    end else begin
                        n_sub = subp;
                        if (subp >= llen) begin
                            n_mode = M_IDLE;
                            s0 = tok(r_lsel[1] ? K_NULL : K_BOOL, r_start, OB'(llen));
                            cnt = 2'd1;
                        end
                    end
                end
                M_NSIGN: begin
                    if (c == "0") n_mode = M_NZERO;
                    else if (dig) n_mode = M_NINT;
                    else begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_NUM, r_start); cnt = 2'd1;
                    end
                end
                M_NZERO: begin
                    if (dig) begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_LZERO, r_start);
                        cnt = 2'd1;
                    end else tail_n = 1'b1;
                end
                M_NINT, M_NFRAC, M_NEXP: begin
                    if (!dig) tail_n = 1'b1;
                end
                M_NFRAC0: begin
                    if (!dig) begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_NUM, r_start); cnt = 2'd1;
                    end else n_mode = M_NFRAC;
                end
                M_NEXP0: begin
                    if (c == "+" || c == "-") n_mode = M_NEXPSIGN;
                    else if (dig) n_mode = M_NEXP;
                    else begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_NUM, r_start); cnt = 2'd1;
                    end
                end
                M_NEXPSIGN: begin
                    if (!dig) begin
                        n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_NUM, r_start); cnt = 2'd1;
                    end else n_mode = M_NEXP;
                end
                default: begin
                    n_mode = M_IDLE;
                    if (ws) begin
                    end else if (c == "{") begin s0 = tok(K_LBRACE, pos, OB'(1)); cnt = 2'd1; end
                    else if (c == "}") begin s0 = tok(K_RBRACE, pos, OB'(1)); cnt = 2'd1; end
                    else if (c == "[") begin s0 = tok(K_LBRACK, pos, OB'(1)); cnt = 2'd1; end
                    else if (c == "]") begin s0 = tok(K_RBRACK, pos, OB'(1)); cnt = 2'd1; end
                    else if (c == ":") begin s0 = tok(K_COLON, pos, OB'(1)); cnt = 2'd1; end
                    else if (c == ",") begin s0 = tok(K_COMMA, pos, OB'(1)); cnt = 2'd1; end
                    else begin
                        n_start = pos;
                        if (c == 8'h22) begin
                            n_esc = 1'b0; n_mode = M_STR;
                        end else if (c == "t" || c == "f" || c == "n") begin
                            n_lsel = (c == "t") ? 2'd0 : ((c == "f") ? 2'd1 : 2'd2);
                            n_sub = 3'd1; n_mode = M_LIT;
                        end else if (c == "-" || dig) begin
                            n_dbl = 1'b0;
                            n_mode = (c == "-") ? M_NSIGN : ((c == "0") ? M_NZERO : M_NINT);
                        end else begin
                            n_halt = 1'b1; s0 = erres(E_TOKEN, pos); cnt = 2'd1;
                        end
                    end
                end
            endcase
            // The byte after a number's digits: extend, end the number, or fail.
            if (tail_n) begin
                if (c == "." && r_mode != M_NFRAC && r_mode != M_NEXP) begin
                    n_dbl = 1'b1; n_mode = M_NFRAC0;
                end else if ((c == "e" || c == "E") && r_mode != M_NEXP) begin
                    n_dbl = 1'b1; n_mode = M_NEXP0;
                end else if (ws || c == "," || c == "]" || c == "}") begin
                    n_mode = M_IDLE;
                    s0 = tok(r_dbl ? K_DOUBLE : K_INT, r_start, pos - r_start);
                    cnt = 2'd1;
                    if (!ws) begin
                        s1 = tok((c == ",") ? K_COMMA : ((c == "]") ? K_RBRACK : K_RBRACE),
                                 pos, OB'(1));
                        cnt = 2'd2;
                    end
                end else begin
                    n_halt = 1'b1; n_mode = M_IDLE; s0 = erres(E_NUM, pos); cnt = 2'd1;
                end
            end
        end
        if (r_halt) cnt = 2'd0;
    end

    assign o_cnt  = (i_step) ? cnt : 2'd0;
    assign o_res0 = s0;
    assign o_res1 = s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pos <= '0; r_start <= '0; r_sub <= '0;
            r_acc <= '0; r_mcls <= '0; r_lsel <= '0; r_esc <= 1'b0;
            r_dbl <= 1'b0; r_halt <= 1'b0;
        end else if (i_step && !r_halt) begin
            r_mode <= n_mode; r_start <= n_start; r_sub <= n_sub; r_acc <= n_acc;
            r_mcls <= n_mcls; r_lsel <= n_lsel; r_esc <= n_esc; r_dbl <= n_dbl;
            r_halt <= n_halt;
            if (!i_eos) r_pos <= r_pos + OB'(1);
        end
    end
endmodule

FILE: rtl/core/json_token_lexer_unit.sv
// Top level of the JSON token lexer: input register, scanner and result queue.
// Depends on jtl_pkg, jtl_scanner and jtl_out_buf.
//
//  channel  | direction | tdata                          | tuser / tlast
//  s_axis   | in        | data_byte                      | tuser: end_of_stream
//  m_axis   | out       | kind, offsets, lengths, error  | tlast: last_of_run
//
// One byte per cycle while the queue has room. A transfer is registered in
// the input register, scanned once the queue has room, and its one or two
// results land in a three-entry queue. Input stalls only while the queue holds
// two or more results; a byte that gives two results can hold input back even
// when the output never stalls. Reset clears the scanner and empties the queue.
// After an error the block takes bytes but gives nothing until reset.
module json_token_lexer_unit #(
    parameter int OFFSET_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tuser,   // [0] end_of_stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] token_kind, [35:4] tok_offset, [67:36] token_length,
    // [71:68] error_code, [103:72] error_offset
    output logic [103:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import jtl_pkg::*;

    logic       r_v, r_eos;
    logic [7:0] r_byte;
    logic       space;
    logic [1:0] cnt;
    t_res       res0, res1, ores;

    // The input register empties whenever the queue has room for two results.
    assign s_axis_tready = !r_v || space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_v <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_byte <= s_axis_tdata;
            r_eos  <= s_axis_tuser;
        end
    end

    jtl_scanner #(.OFFSET_BITS(OFFSET_BITS)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(r_v && space),
        .i_byte(r_byte), .i_eos(r_eos), .o_cnt(cnt), .o_res0(res0), .o_res1(res1)
    );

    jtl_out_buf u_obuf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(r_v && space), .i_cnt(cnt),
        .i_res0(res0), .i_res1(res1), .o_space(space), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_res(ores), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {ores.eoff, ores.err, ores.tlen, ores.toff, ores.kind};
endmodule
